### sv/id_set_table_macros.svh
// Assertion macros for the identifier set table.
// Each use names the label, the clock, the reset, the antecedent, the
// consequent and the message.
`ifndef ID_SET_TABLE_MACROS_SVH
`define ID_SET_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define IST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define IST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/ist_pkg.sv
`timescale 1ns / 1ps

package ist_pkg;

  localparam int ID_W    = 32;
  localparam int OP_W    = 2;
  localparam int CAP_W   = 6;
  localparam int ST_W    = 3;
  localparam int OCC_W   = 6;
  localparam int MAX_OUT = 32;
  localparam int OCC_MAX = 63;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_SNAPSHOT = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a new item and clear the scan state
    logic read;    // read the slot under the scan index
    logic eval;    // evaluate the slot fetched by the last read
    logic next;    // advance the scan index
    logic finish;  // apply the update and load the single result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;       // nothing to scan: zero identifier or empty snapshot
    logic is_snap;    // the item is a snapshot
    logic idx_last;   // scan index is on the last slot
    logic rd_occ;     // slot just read is occupied
    logic snap_last;  // next snapshot entry is the final one
    logic out_full;   // output register cannot take a result this cycle
  } sts_t;

endpackage

### sv/ist_in_if.sv
`timescale 1ns / 1ps

interface ist_in_if;
  logic                     valid;
  logic                     ready;
  logic [ist_pkg::OP_W-1:0]  operation;
  logic [ist_pkg::ID_W-1:0]  ident;
  logic [ist_pkg::CAP_W-1:0] capacity;

  modport source (output valid, output operation, output ident, output capacity,
                  input ready);
  modport sink   (input valid, input operation, input ident, input capacity,
                  output ready);
endinterface

### sv/ist_out_if.sv
`timescale 1ns / 1ps

interface ist_out_if;
  logic                     valid;
  logic                     ready;
  logic [ist_pkg::ST_W-1:0]  status;
  logic                     found;
  logic [ist_pkg::ID_W-1:0]  entry_ident;
  logic                     entry_valid;
  logic                     last;
  logic [ist_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, output status, output found, output entry_ident,
                  output entry_valid, output last, output occupancy, input ready);
  modport sink   (input valid, input status, input found, input entry_ident,
                  input entry_valid, input last, input occupancy, output ready);
endinterface

### sv/ist_ctrl.sv
`timescale 1ns / 1ps

module ist_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ist_pkg::sts_t sts,
  output ist_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else begin
          cmd.read  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.is_snap) begin
          cmd.eval = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_READ;
          end
        end else if (!(sts.rd_occ && sts.out_full)) begin
          cmd.eval = sts.rd_occ;
          if ((sts.rd_occ && sts.snap_last) || sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/ist_datapath.sv
`timescale 1ns / 1ps

module ist_datapath #(
  parameter int SLOTS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ist_pkg::cmd_t             cmd,
  output ist_pkg::sts_t             sts,
  input  logic [ist_pkg::OP_W-1:0]  in_operation,
  input  logic [ist_pkg::ID_W-1:0]  in_ident,
  input  logic [ist_pkg::CAP_W-1:0] in_capacity,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ist_pkg::ST_W-1:0]  out_status,
  output logic                      out_found,
  output logic [ist_pkg::ID_W-1:0]  out_entry_ident,
  output logic                      out_entry_valid,
  output logic                      out_last,
  output logic [ist_pkg::OCC_W-1:0] out_occupancy
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Slot store: identifiers in a memory, occupancy in flip-flops.
  logic [ist_pkg::ID_W-1:0] slot_mem_r [SLOTS];
  logic [SLOTS-1:0]         slot_vld_r;

  ist_pkg::op_t              op_r;
  logic [ist_pkg::ID_W-1:0]  id_r;
  logic [ist_pkg::CAP_W-1:0] cap_r;
  logic [IW-1:0]             idx_r;
  logic [ist_pkg::ID_W-1:0]  rd_data_r;
  logic                      rd_vld_r;
  logic                      hit_r;
  logic [IW-1:0]             hit_idx_r;
  logic                      free_r;
  logic [IW-1:0]             free_idx_r;
  logic [ist_pkg::CAP_W-1:0] emit_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      out_valid_r;

  logic [ist_pkg::CAP_W-1:0] limit;
  logic                      rd_hit;
  logic                      mem_we;
  logic                      vld_clr;
  logic                      snap_emit;
  ist_pkg::status_t          fin_status;
  logic                      fin_found;
  logic [ist_pkg::OCC_W-1:0] occ_nxt;
  logic [31:0]               cnt_ext;

  // Entries a snapshot sends: the smaller of the clamped capacity and the count.
  always_comb begin
    if (32'(cnt_r) < 32'(cap_r)) begin
      limit = ist_pkg::CAP_W'(cnt_r);
    end else begin
      limit = cap_r;
    end
  end

  assign rd_hit    = rd_vld_r && (rd_data_r == id_r);
  assign snap_emit = cmd.eval && (op_r == ist_pkg::OP_SNAPSHOT) && rd_vld_r;

  always_comb begin
    fin_status = ist_pkg::ST_OK;
    fin_found  = 1'b0;
    mem_we     = 1'b0;
    vld_clr    = 1'b0;
    cnt_nxt    = cnt_r;
    if (op_r != ist_pkg::OP_SNAPSHOT && id_r == '0) begin
      fin_status = ist_pkg::ST_ZERO;
    end else begin
      unique case (op_r)
        ist_pkg::OP_ADD: begin
          if (hit_r) begin
            fin_status = ist_pkg::ST_DUP;
          end else if (!free_r) begin
            fin_status = ist_pkg::ST_FULL;
          end else begin
            mem_we  = cmd.finish;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end
        end
        ist_pkg::OP_REMOVE: begin
          if (!hit_r) begin
            fin_status = ist_pkg::ST_NOTFOUND;
          end else begin
            vld_clr = cmd.finish;
            cnt_nxt = CW'(cnt_r - 1'b1);
          end
        end
        ist_pkg::OP_CONTAINS: fin_found = hit_r;
        ist_pkg::OP_SNAPSHOT: fin_status = ist_pkg::ST_OK;
        default: fin_status = ist_pkg::ST_OK;
      endcase
    end
  end

  // Occupancy after the operation, saturated to the field width.
  always_comb begin
    cnt_ext = 32'(cnt_nxt);
    if (cnt_ext > 32'(ist_pkg::OCC_MAX)) begin
      occ_nxt = ist_pkg::OCC_W'(ist_pkg::OCC_MAX);
    end else begin
      occ_nxt = cnt_ext[ist_pkg::OCC_W-1:0];
    end
  end

  always_comb begin
    sts           = '0;
    sts.is_snap   = (op_r == ist_pkg::OP_SNAPSHOT);
    sts.skip      = sts.is_snap ? (limit == '0) : (id_r == '0);
    sts.idx_last  = (idx_r == IW'(SLOTS - 1));
    sts.rd_occ    = rd_vld_r;
    sts.snap_last = (ist_pkg::CAP_W'(emit_r + 1'b1) == limit);
    sts.out_full  = out_valid_r && !out_ready;
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[free_idx_r] <= id_r;
    end
    if (cmd.read) begin
      rd_data_r <= slot_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      idx_r       <= '0;
      emit_r      <= '0;
    end else begin
      if (cmd.start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        idx_r  <= '0;
        emit_r <= '0;
      end
      if (cmd.read) begin
        rd_vld_r <= slot_vld_r[idx_r];
      end
      if (cmd.eval && op_r != ist_pkg::OP_SNAPSHOT) begin
        if (rd_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!rd_vld_r && !free_r) begin
          free_r <= 1'b1;
        end
      end
      if (snap_emit) begin
        emit_r <= ist_pkg::CAP_W'(emit_r + 1'b1);
      end
      if (cmd.next) begin
        idx_r <= IW'(idx_r + 1'b1);
      end
      if (mem_we) begin
        slot_vld_r[free_idx_r] <= 1'b1;
      end
      if (vld_clr) begin
        slot_vld_r[hit_idx_r] <= 1'b0;
      end
      if (cmd.finish) begin
        cnt_r <= cnt_nxt;
      end
      if (cmd.finish || snap_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= ist_pkg::op_t'(in_operation);
      id_r <= in_ident;
      if (in_capacity > ist_pkg::CAP_W'(ist_pkg::MAX_OUT)) begin
        cap_r <= ist_pkg::CAP_W'(ist_pkg::MAX_OUT);
      end else begin
        cap_r <= in_capacity;
      end
    end
    if (cmd.eval && op_r != ist_pkg::OP_SNAPSHOT) begin
      if (rd_hit && !hit_r) begin
        hit_idx_r <= idx_r;
      end
      if (!rd_vld_r && !free_r) begin
        free_idx_r <= idx_r;
      end
    end
    if (snap_emit) begin
      out_status      <= ist_pkg::ST_OK;
      out_found       <= 1'b0;
      out_entry_ident <= rd_data_r;
      out_entry_valid <= 1'b1;
      out_last        <= sts.snap_last;
      out_occupancy   <= occ_nxt;
    end else if (cmd.finish) begin
      out_status      <= fin_status;
      out_found       <= fin_found;
      out_entry_ident <= '0;
      out_entry_valid <= 1'b0;
      out_last        <= 1'b1;
      out_occupancy   <= occ_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/id_set_table.sv
// Identifier set table. The block keeps SLOTS 32-bit identifiers, a valid
// bit per slot marking it occupied, and takes one item at a time: add,
// remove, contains or snapshot. Add refuses a duplicate, otherwise fills
// the lowest empty slot or reports the table full; remove clears the
// matching slot; contains answers in found; for these three an identifier
// of zero is refused with the invalid status and changes nothing. Snapshot
// sends the occupied slots in slot order, at most the requested capacity
// and never more than 32, one result each, with last on the final one;
// with nothing to send it gives a single empty result. Every result
// carries the occupancy after the operation. The slots sit in a memory
// with one read port, and the controller scans one slot at a time, a read
// state addressing it and an evaluate state comparing it; add, remove and
// contains visit every slot before a finish state loads the result, and a
// zero identifier goes straight to the finish state. A snapshot stops
// after its final entry, reading only the slots up to and including the
// slot of that entry, and waits while the output is still held. A new
// item is accepted only when the controller is idle, while the previous
// result may still wait in the output register. Reset empties the table
// at once through per-slot valid bits.
`timescale 1ns / 1ps
`include "id_set_table_macros.svh"

module id_set_table #(
  parameter int SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);

  ist_pkg::cmd_t cmd;
  ist_pkg::sts_t sts;

  // The controller sequences the scan; the datapath holds the table.
  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ist_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_ident        (in_ch.ident),
    .in_capacity     (in_ch.capacity),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found       (out_ch.found),
    .out_entry_ident (out_ch.entry_ident),
    .out_entry_valid (out_ch.entry_valid),
    .out_last        (out_ch.last),
    .out_occupancy   (out_ch.occupancy)
  );

  // Once an item is taken, the controller is busy on the next cycle.
  `IST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted an item but stayed ready")
  // A result is never loaded over one that is still waiting.
  `IST_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.finish || (cmd.eval && sts.is_snap && sts.rd_occ), !sts.out_full, "result loaded while output held")
  // Occupancy never exceeds the number of slots.
  `IST_ASSERT_SAME(a_occ_bound, clk, rst_n, out_ch.valid, 32'(out_ch.occupancy) <= 32'(SLOTS), "occupancy above slot count")
  // A snapshot entry always reports success and no membership flag.
  `IST_ASSERT_SAME(a_entry_fields, clk, rst_n, out_ch.valid && out_ch.entry_valid, out_ch.status == 3'(ist_pkg::ST_OK) && !out_ch.found, "snapshot entry with bad status")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

import ist_pkg::*;

// One result as it leaves the block.
typedef struct packed {
  status_t           status;
  logic              found;
  logic [ID_W-1:0]   entry_ident;
  logic              entry_valid;
  logic              last;
  logic [OCC_W-1:0]  occupancy;
} table_reply_t;

// Mirror of the identifier table. It follows every accepted item and keeps
// the replies that the block still owes, oldest first.
class id_table_mirror;
  logic [ID_W-1:0] slot_ident [32];
  int unsigned     occupied;
  table_reply_t    owed_replies [$];
  int unsigned     mismatches;

  function new();
    foreach (slot_ident[i]) slot_ident[i] = '0;
    occupied = 0;
    mismatches = 0;
  endfunction

  function int unsigned outstanding();
    return owed_replies.size();
  endfunction

  function logic [OCC_W-1:0] occupancy_now();
    return (occupied > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(occupied);
  endfunction

  // Index of the slot holding the identifier, or -1.
  function int slot_of(logic [ID_W-1:0] ident);
    foreach (slot_ident[i])
      if (slot_ident[i] == ident) return i;
    return -1;
  endfunction

  function void apply_request(op_t op, logic [ID_W-1:0] ident, logic [CAP_W-1:0] capacity);
    table_reply_t r;
    int idx;
    int limit;
    int total;
    int sent;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    if (op == OP_SNAPSHOT) begin
      limit = (capacity > MAX_OUT) ? MAX_OUT : int'(capacity);
      total = (limit < int'(occupied)) ? limit : int'(occupied);
      if (total == 0) begin
        r.occupancy = occupancy_now();
        owed_replies.push_back(r);
        return;
      end
      sent = 0;
      foreach (slot_ident[i]) begin
        if (sent < total && slot_ident[i] != '0) begin
          sent++;
          r.entry_ident = slot_ident[i];
          r.entry_valid = 1'b1;
          r.last = (sent == total);
          r.occupancy = occupancy_now();
          owed_replies.push_back(r);
        end
      end
      return;
    end
    if (ident == '0) begin
      r.status = ST_ZERO;
    end else begin
      idx = slot_of(ident);
      case (op)
        OP_ADD: begin
          // The duplicate test comes first, so a full table still reports it.
          if (idx >= 0) begin
            r.status = ST_DUP;
          end else begin
            idx = slot_of('0);
            if (idx < 0) begin
              r.status = ST_FULL;
            end else begin
              slot_ident[idx] = ident;
              occupied++;
            end
          end
        end
        OP_REMOVE: begin
          if (idx < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            slot_ident[idx] = '0;
            occupied--;
          end
        end
        default: r.found = (idx >= 0);
      endcase
    end
    r.occupancy = occupancy_now();
    owed_replies.push_back(r);
  endfunction

  function void check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  function void compare_reply(logic [ST_W-1:0] status, logic found, logic [ID_W-1:0] entry_ident,
                              logic entry_valid, logic last, logic [OCC_W-1:0] occupancy);
    table_reply_t want;
    if (owed_replies.size() == 0) begin
      $error("result with status %0h entry %0h arrived with none outstanding",
             status, entry_ident);
      mismatches++;
      return;
    end
    want = owed_replies.pop_front();
    check_field("status", want.status, status);
    check_field("found", want.found, found);
    check_field("entry_ident", want.entry_ident, entry_ident);
    check_field("entry_valid", want.entry_valid, entry_valid);
    check_field("last", want.last, last);
    check_field("occupancy", want.occupancy, occupancy);
  endfunction
endclass

module testbench;

  localparam int TABLE_SLOTS = 32;
  // A full scan reads and compares every slot; leave room after the
  // last result for anything the block should not have sent.
  localparam int SETTLE_CYCLES = 4 * TABLE_SLOTS + 10;
  localparam int CHUNK_ITEMS = 40;

  // Shape of a stretch of random traffic.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND
  } mix_t;

  logic clk;
  logic rst_n;

  ist_in_if  in_ch ();
  ist_out_if out_ch ();

  id_set_table #(.SLOTS(TABLE_SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  id_table_mirror table_model = new();

  // Percentages of cycles in which the sender holds back an item and the
  // receiver refuses one. They change from phase to phase.
  int send_idle_pct;
  int recv_stall_pct;

  // Identifiers added recently. Picking from here gives hits for remove,
  // contains and duplicate adds; fresh random values give the misses.
  logic [ID_W-1:0] recent_ids [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides at every edge whether it takes the next result.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both channels are sampled at the edge, before any of this edge's
  // updates land. A result is checked before the item accepted at the same
  // edge is applied, since that result always belongs to an older item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        table_model.compare_reply(out_ch.status, out_ch.found, out_ch.entry_ident,
                                  out_ch.entry_valid, out_ch.last, out_ch.occupancy);
      if (in_ch.valid && in_ch.ready)
        table_model.apply_request(op_t'(in_ch.operation), in_ch.ident, in_ch.capacity);
    end
  end

  // Phase 0 runs flat out, 1 starves the block, 2 backs up its output and
  // 3 does a little of both.
  task automatic set_idle_phase(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  // Offers one item and returns at the edge where the block takes it.
  task automatic send_item(op_t op, logic [ID_W-1:0] ident, logic [CAP_W-1:0] capacity);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.ident     <= ident;
    in_ch.capacity  <= capacity;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] known_id();
    if (recent_ids.size() == 0) return $urandom();
    return recent_ids[$urandom_range(recent_ids.size() - 1)];
  endfunction

  // The capacity field runs past 32 on purpose: a larger request must
  // still stop at the entries present.
  function automatic logic [CAP_W-1:0] random_capacity();
    if ($urandom_range(3) == 0) return CAP_W'(MAX_OUT);
    return CAP_W'($urandom_range(63));
  endfunction

  // Noise may carry the zero identifier, which add, remove and contains must refuse.
  function automatic logic [ID_W-1:0] noise_id();
    if ($urandom_range(3) == 0) return '0;
    return $urandom();
  endfunction

  // Random traffic. Fill stretches push the table to full, where fresh adds
  // must report the table full and repeats must still report a duplicate.
  // Drain stretches empty it again so that snapshots see every occupancy.
  task automatic run_random_chunk(mix_t flavor, int count);
    int n;
    int roll;
    op_t op;
    logic [ID_W-1:0] ident;
    logic is_fresh;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      ident = known_id();
      is_fresh = 1'b0;
      op = OP_CONTAINS;
      case (flavor)
        MIX_FILL: begin
          if (roll < 70) begin
            op = OP_ADD;
            is_fresh = 1'b1;
          end else if (roll < 80) begin
            op = OP_ADD;
          end else if (roll < 88) begin
            op = OP_SNAPSHOT;
          end else if (roll < 95) begin
            op = OP_CONTAINS;
          end else begin
            op = op_t'($urandom_range(3));
            ident = noise_id();
          end
        end
        MIX_DRAIN: begin
          if (roll < 60) begin
            op = OP_REMOVE;
          end else if (roll < 70) begin
            op = OP_REMOVE;
            ident = $urandom();
          end else if (roll < 80) begin
            op = OP_CONTAINS;
            if (roll[0]) ident = $urandom();
          end else if (roll < 92) begin
            op = OP_SNAPSHOT;
          end else begin
            op = op_t'($urandom_range(3));
            ident = noise_id();
          end
        end
        default: begin
          if (roll < 30) begin
            op = OP_ADD;
            is_fresh = 1'b1;
          end else if (roll < 40) begin
            op = OP_ADD;
          end else if (roll < 60) begin
            op = OP_REMOVE;
          end else if (roll < 75) begin
            op = OP_CONTAINS;
            if (roll[0]) ident = $urandom();
          end else if (roll < 95) begin
            op = OP_SNAPSHOT;
          end else begin
            op = op_t'($urandom_range(3));
            ident = noise_id();
          end
        end
      endcase
      if (is_fresh) begin
        ident = $urandom();
        if (ident != '0) recent_ids.push_back(ident);
        if (recent_ids.size() > 48) void'(recent_ids.pop_front());
      end
      send_item(op, ident, random_capacity());
    end
  endtask

  initial begin
    mix_t chunk_plan [10];
    int chunk;
    chunk_plan = '{MIX_FILL, MIX_FILL, MIX_BLEND, MIX_DRAIN, MIX_DRAIN,
                   MIX_FILL, MIX_FILL, MIX_FILL, MIX_BLEND, MIX_DRAIN};
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.ident     = '0;
    in_ch.capacity  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: the empty table, the zero identifier on every
    // operation, the extreme identifiers, a duplicate, hits and misses,
    // snapshots with no, one, full and oversized capacity, and a freed
    // slot being reused as the lowest empty one.
    set_idle_phase(3);
    send_item(OP_SNAPSHOT, '0, CAP_W'(MAX_OUT));
    send_item(OP_ADD,      '0, '0);
    send_item(OP_REMOVE,   '0, '1);
    send_item(OP_CONTAINS, '0, '0);
    send_item(OP_ADD,      32'hFFFF_FFFF, '1);
    send_item(OP_ADD,      32'h0000_0001, '0);
    send_item(OP_ADD,      32'hFFFF_FFFF, '0);
    send_item(OP_CONTAINS, 32'h0000_0001, '0);
    send_item(OP_CONTAINS, 32'h0000_0002, '0);
    send_item(OP_REMOVE,   32'h0000_0002, '0);
    send_item(OP_SNAPSHOT, 32'hFFFF_FFFF, '0);
    send_item(OP_SNAPSHOT, '0, '1);
    send_item(OP_SNAPSHOT, '0, CAP_W'(1));
    send_item(OP_REMOVE,   32'h0000_0001, '0);
    send_item(OP_ADD,      32'h8000_0000, '0);
    send_item(OP_SNAPSHOT, '0, CAP_W'(MAX_OUT));
    send_item(OP_REMOVE,   32'hFFFF_FFFF, '0);
    send_item(OP_REMOVE,   32'h8000_0000, '0);
    send_item(OP_SNAPSHOT, '0, CAP_W'(5));

    for (chunk = 0; chunk < 10; chunk++) begin
      set_idle_phase(chunk);
      run_random_chunk(chunk_plan[chunk], CHUNK_ITEMS);
    end
    in_ch.valid <= 1'b0;

    // Wait for every owed result, then give the block time to send anything
    // it should not.
    while (table_model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (table_model.mismatches == 0 && table_model.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A correct run ends far sooner; reaching this means the block hung.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
